### hw/rtl/vsar_pkg.sv
// Package for the video scroll and address registers.
// Holds the operation codes, address field masks and fetch address bases.
// Used by vram_scroll_address_registers; depends on nothing.
package vsar_pkg;

    typedef enum logic [3:0] {
        OP_CTRL_WR   = 4'd0,
        OP_MASK_WR   = 4'd1,
        OP_SCROLL_WR = 4'd2,
        OP_ADDR_WR   = 4'd3,
        OP_DATA      = 4'd4,
        OP_STATUS_RD = 4'd5,
        OP_INC_X     = 4'd6,
        OP_INC_Y     = 4'd7,
        OP_XFER_X    = 4'd8,
        OP_XFER_Y    = 4'd9
    } t_op;

    localparam int unsigned ADDR_W = 15;
    localparam int unsigned ACC_W  = 14;

    localparam logic [ADDR_W-1:0] HORIZ_BITS = 15'h041F;
    localparam logic [ADDR_W-1:0] VERT_BITS  = 15'h7BE0;

    localparam logic [4:0] COARSE_MAX      = 5'd31;
    localparam logic [4:0] COARSE_Y_LAST   = 5'd29;
    localparam logic [2:0] FINE_Y_MAX      = 3'd7;

    localparam logic [ACC_W-1:0] TILE_BASE = 14'h2000;
    localparam logic [ACC_W-1:0] ATTR_BASE = 14'h23C0;

endpackage

### hw/rtl/vram_scroll_address_registers.sv
// Current and temporary video address, fine X scroll and write toggle.
// Decodes bus and render-timing requests and forms the fetch addresses.
// Depends on vsar_pkg.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-------------------------------------------
//  in      | into      | i_valid / o_stall   | i_op, i_value
//  out     | out of    | o_valid / i_stall   | o_current_address, o_access_address,
//          |           |                     | o_fine_scroll_x, o_second_write_next,
//          |           |                     | o_tile_fetch_address, o_attribute_fetch_address
//
// A request is registered in the input stage, and its result in the address state and o_valid.
// One request is accepted in every cycle while the result side does not stall.
// The rate is set by the single register update of the address state per cycle.
// Reset clears the address state, the toggle, the enables and both valid flags.
// A stalled result holds, and the input stage fills before o_stall rises.
module vram_scroll_address_registers (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_op,
    input  logic [7:0]  i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_current_address,
    output logic [13:0] o_access_address,
    output logic [2:0]  o_fine_scroll_x,
    output logic        o_second_write_next,
    output logic [13:0] o_tile_fetch_address,
    output logic [13:0] o_attribute_fetch_address
);

    logic        r_in_valid;
    logic [3:0]  r_op;
    logic [7:0]  r_value;
    logic        r_out_valid;
    logic [13:0] r_access;

    logic [14:0] r_cur;
    logic [14:0] r_tmp;
    logic [2:0]  r_fine_x;
    logic        r_toggle;
    logic        r_step_32;
    logic        r_show_bg;
    logic        r_show_spr;

    logic [14:0] n_cur;
    logic [14:0] n_tmp;
    logic [2:0]  n_fine_x;
    logic        n_toggle;
    logic        n_step_32;
    logic        n_show_bg;
    logic        n_show_spr;
    logic [13:0] n_access;

    logic        advance;
    logic        process;
    logic        rendering;
    logic [14:0] inc_x;
    logic [14:0] inc_y;
    logic [4:0]  cy;
    logic [4:0]  n_cy;

    assign advance   = !r_out_valid || !i_stall;
    assign process   = r_in_valid && advance;
    assign o_stall   = r_in_valid && !advance;
    assign rendering = r_show_bg || r_show_spr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
    end

    always_comb begin
        if (r_cur[4:0] == vsar_pkg::COARSE_MAX) begin
            inc_x = {r_cur[14:11], ~r_cur[10], r_cur[9:5], 5'd0};
        end else begin
            inc_x = r_cur + 15'd1;
        end
    end

    always_comb begin
        cy = r_cur[9:5];
        priority if (cy == vsar_pkg::COARSE_Y_LAST || cy == vsar_pkg::COARSE_MAX) begin
            n_cy = 5'd0;
        end else begin
            n_cy = cy + 5'd1;
        end
        if (r_cur[14:12] != vsar_pkg::FINE_Y_MAX) begin
            inc_y = r_cur + 15'h1000;
        end else if (cy == vsar_pkg::COARSE_Y_LAST) begin
            inc_y = {3'd0, ~r_cur[11], r_cur[10], n_cy, r_cur[4:0]};
        end else begin
            inc_y = {3'd0, r_cur[11:10], n_cy, r_cur[4:0]};
        end
    end

    always_comb begin
        n_cur      = r_cur;
        n_tmp      = r_tmp;
        n_fine_x   = r_fine_x;
        n_toggle   = r_toggle;
        n_step_32  = r_step_32;
        n_show_bg  = r_show_bg;
        n_show_spr = r_show_spr;
        n_access   = '0;
        unique case (r_op)
            vsar_pkg::OP_CTRL_WR: begin
                n_tmp     = {r_tmp[14:12], r_value[1:0], r_tmp[9:0]};
                n_step_32 = r_value[2];
            end
            vsar_pkg::OP_MASK_WR: begin
                n_show_bg  = r_value[3];
                n_show_spr = r_value[4];
            end
            vsar_pkg::OP_SCROLL_WR: begin
                if (!r_toggle) begin
                    n_fine_x = r_value[2:0];
                    n_tmp    = {r_tmp[14:5], r_value[7:3]};
                end else begin
                    n_tmp = {r_value[2:0], r_tmp[11:10], r_value[7:3], r_tmp[4:0]};
                end
                n_toggle = !r_toggle;
            end
            vsar_pkg::OP_ADDR_WR: begin
                if (!r_toggle) begin
                    n_tmp = {1'b0, r_value[5:0], r_tmp[7:0]};
                end else begin
                    n_tmp = {r_tmp[14:8], r_value};
                    n_cur = {r_tmp[14:8], r_value};
                end
                n_toggle = !r_toggle;
            end
            vsar_pkg::OP_DATA: begin
                n_access = r_cur[13:0];
                n_cur    = r_cur + (r_step_32 ? 15'd32 : 15'd1);
            end
            vsar_pkg::OP_STATUS_RD: begin
                n_toggle = 1'b0;
            end
            vsar_pkg::OP_INC_X: begin
                if (rendering) begin
                    n_cur = inc_x;
                end
            end
            vsar_pkg::OP_INC_Y: begin
                if (rendering) begin
                    n_cur = inc_y;
                end
            end
            vsar_pkg::OP_XFER_X: begin
                if (rendering) begin
                    n_cur = (r_cur & ~vsar_pkg::HORIZ_BITS) | (r_tmp & vsar_pkg::HORIZ_BITS);
                end
            end
            vsar_pkg::OP_XFER_Y: begin
                if (rendering) begin
                    n_cur = (r_cur & ~vsar_pkg::VERT_BITS) | (r_tmp & vsar_pkg::VERT_BITS);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_tmp       <= '0;
            r_fine_x    <= '0;
            r_toggle    <= 1'b0;
            r_step_32   <= 1'b0;
            r_show_bg   <= 1'b0;
            r_show_spr  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (process) begin
                r_cur      <= n_cur;
                r_tmp      <= n_tmp;
                r_fine_x   <= n_fine_x;
                r_toggle   <= n_toggle;
                r_step_32  <= n_step_32;
                r_show_bg  <= n_show_bg;
                r_show_spr <= n_show_spr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_access <= n_access;
        end
    end

    assign o_valid                   = r_out_valid;
    assign o_current_address         = r_cur;
    assign o_access_address          = r_access;
    assign o_fine_scroll_x           = r_fine_x;
    assign o_second_write_next       = r_toggle;
    assign o_tile_fetch_address      = vsar_pkg::TILE_BASE | {2'b00, r_cur[11:0]};
    assign o_attribute_fetch_address = vsar_pkg::ATTR_BASE
                                     | {2'b00, r_cur[11:10], 4'd0, r_cur[9:7], r_cur[4:2]};

    a_status_clears_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_op == vsar_pkg::OP_STATUS_RD) |=> !r_toggle)
        else $error("Toggle still set after a status read.");

    a_idle_render_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && !rendering && (r_op == vsar_pkg::OP_INC_X || r_op == vsar_pkg::OP_INC_Y
            || r_op == vsar_pkg::OP_XFER_X || r_op == vsar_pkg::OP_XFER_Y)) |=> $stable(r_cur))
        else $error("Current address changed by a render request while rendering is off.");

    a_access_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_op != vsar_pkg::OP_DATA) |=> (r_access == '0))
        else $error("Access address not zero for a request other than a data access.");

    a_state_holds_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> ($stable(r_cur) && $stable(r_tmp) && $stable(r_toggle)))
        else $error("Address state moved while the result was stalled.");

    a_stall_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("Input stalled without a pending request behind a stalled result.");

endmodule
